### rtl/tapt_pkg.sv
// shared types and constants of the timed actuator position tracker
package tapt_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned PosW  = 16;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [PosW-1:0] MaxPositionRst  = 16'd20000;
  localparam logic [PosW-1:0] HallTimeoutRst  = 16'd100;
  localparam logic [PosW-1:0] EndExtraTimeRst = 16'd5000;
  localparam logic [PosW-1:0] GoalPosRst      = 16'hFFFF;
  localparam logic [PosW-1:0] Sat16           = 16'hFFFF;

  // floor(p / 100) = (p * RecipHundred) >> RecipShift for any 16 bit p
  localparam int unsigned    RecipShift   = 24;
  localparam logic [17:0]    RecipHundred = 18'd167773;

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 3'd0,
    OP_HALL  = 3'd1,
    OP_MOVE  = 3'd2,
    OP_STOP  = 3'd3,
    OP_LOAD  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    MODE_STOPPED  = 3'b001,
    MODE_FORWARD  = 3'b010,
    MODE_BACKWARD = 3'b100
  } mode_e;

  localparam logic [1:0] MotionStopped  = 2'd0;
  localparam logic [1:0] MotionForward  = 2'd1;
  localparam logic [1:0] MotionBackward = 2'd2;

  typedef enum logic [1:0] {
    REG_MAX_POSITION   = 2'd0,
    REG_HALL_TIMEOUT   = 2'd1,
    REG_END_EXTRA_TIME = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [PosW-1:0] max_position;
    logic [PosW-1:0] hall_timeout;
    logic [PosW-1:0] end_extra_time;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic [PosW-1:0] target;
  } item_t;

  typedef struct packed {
    logic            drive_forward;
    logic            drive_backward;
    logic [1:0]      motion;
    logic [PosW-1:0] position;
    logic            move_done;
  } res_t;

endpackage

### rtl/tapt_if.sv
// valid/ready channel interfaces for command items and results
interface tapt_in_if import tapt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OpW-1:0]  operation;
  logic [PosW-1:0] target;

  modport source (output valid, output operation, output target, input ready);
  modport sink (input valid, input operation, input target, output ready);
endinterface

interface tapt_out_if import tapt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            drive_forward;
  logic            drive_backward;
  logic [1:0]      motion;
  logic [PosW-1:0] position;
  logic            move_done;
  logic [PosW-1:0] saved_position;

  modport source (output valid, output drive_forward, output drive_backward, output motion,
                  output position, output move_done, output saved_position, input ready);
  modport sink (input valid, input drive_forward, input drive_backward, input motion,
                input position, input move_done, input saved_position, output ready);
endinterface

### rtl/tapt_cfg.sv
// apb configuration registers
module tapt_cfg import tapt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_MAX_POSITION:   cfg_d.max_position   = pwdata[PosW-1:0];
        REG_HALL_TIMEOUT:   cfg_d.hall_timeout   = pwdata[PosW-1:0];
        REG_END_EXTRA_TIME: cfg_d.end_extra_time = pwdata[PosW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_POSITION:   prdata = {{(DataW-PosW){1'b0}}, cfg_q.max_position};
      REG_HALL_TIMEOUT:   prdata = {{(DataW-PosW){1'b0}}, cfg_q.hall_timeout};
      REG_END_EXTRA_TIME: prdata = {{(DataW-PosW){1'b0}}, cfg_q.end_extra_time};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_position   <= MaxPositionRst;
      cfg_q.hall_timeout   <= HallTimeoutRst;
      cfg_q.end_extra_time <= EndExtraTimeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/tapt_core.sv
// tracker state and per-item next-state logic
module tapt_core import tapt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  mode_e           mode_q, mode_d;
  logic [PosW-1:0] cur_pos_q, cur_pos_d;
  logic [PosW-1:0] goal_q, goal_d;
  logic [PosW-1:0] limit_q, limit_d;
  logic [PosW-1:0] run_q, run_d;
  logic [PosW-1:0] pulse_q, pulse_d;

  logic [PosW:0]   fwd_sum;
  logic [PosW-1:0] fwd_pos, bwd_raw, bwd_pos, halt_pos;
  logic [PosW-1:0] run_inc, pulse_inc, span;
  logic            moving, goal_end, tgt_end, done;

  assign moving    = (mode_q != MODE_STOPPED);
  assign run_inc   = (run_q == Sat16) ? run_q : run_q + 16'd1;
  assign pulse_inc = (pulse_q == Sat16) ? pulse_q : pulse_q + 16'd1;
  assign goal_end  = (goal_q == '0) || (goal_q == cfg_i.max_position);
  assign tgt_end   = (item_i.target == '0) || (item_i.target == cfg_i.max_position);
  assign span      = (cur_pos_q >= item_i.target) ? cur_pos_q - item_i.target
                                                  : item_i.target - cur_pos_q;

  // position estimate from elapsed run time
  assign fwd_sum  = {1'b0, cur_pos_q} + {1'b0, run_q};
  assign fwd_pos  = (fwd_sum > {1'b0, cfg_i.max_position}) ? cfg_i.max_position
                                                          : fwd_sum[PosW-1:0];
  assign bwd_raw  = (run_q >= cur_pos_q) ? '0 : cur_pos_q - run_q;
  assign bwd_pos  = (bwd_raw > cfg_i.max_position) ? cfg_i.max_position : bwd_raw;
  assign halt_pos = (mode_q == MODE_FORWARD) ? fwd_pos : bwd_pos;

  always_comb begin
    mode_d    = mode_q;
    cur_pos_d = cur_pos_q;
    goal_d    = goal_q;
    limit_d   = limit_q;
    run_d     = run_q;
    pulse_d   = pulse_q;
    done      = 1'b0;
    if (step_i) begin
      unique case (item_i.operation)
        OP_TICK: begin
          if (moving) begin
            run_d   = run_inc;
            pulse_d = pulse_inc;
            if (run_inc >= limit_q || pulse_inc > cfg_i.hall_timeout) begin
              if (pulse_inc < cfg_i.hall_timeout && goal_end) begin
                run_d   = '0;
                limit_d = cfg_i.end_extra_time;
              end else begin
                cur_pos_d = goal_q;
                mode_d    = MODE_STOPPED;
                done      = 1'b1;
              end
            end
          end
        end
        OP_HALL: pulse_d = '0;
        OP_MOVE: begin
          goal_d  = item_i.target;
          limit_d = tgt_end ? cfg_i.max_position : span;
          if (cur_pos_q < item_i.target || item_i.target >= cfg_i.max_position) begin
            run_d   = '0;
            pulse_d = '0;
            mode_d  = MODE_FORWARD;
          end else if (cur_pos_q > item_i.target || item_i.target == '0) begin
            run_d   = '0;
            pulse_d = '0;
            mode_d  = MODE_BACKWARD;
          end else if (moving) begin
            cur_pos_d = halt_pos;
            mode_d    = MODE_STOPPED;
            done      = 1'b1;
          end
        end
        OP_STOP: begin
          if (moving) begin
            cur_pos_d = halt_pos;
            mode_d    = MODE_STOPPED;
            done      = 1'b1;
          end
        end
        OP_LOAD: cur_pos_d = item_i.target;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o.drive_forward  = (mode_d == MODE_FORWARD);
    res_o.drive_backward = (mode_d == MODE_BACKWARD);
    unique case (mode_d)
      MODE_FORWARD:  res_o.motion = MotionForward;
      MODE_BACKWARD: res_o.motion = MotionBackward;
      default:       res_o.motion = MotionStopped;
    endcase
    res_o.position  = cur_pos_d;
    res_o.move_done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_STOPPED;
      cur_pos_q <= '0;
      goal_q    <= GoalPosRst;
      limit_q   <= '0;
      run_q     <= '0;
      pulse_q   <= '0;
    end else begin
      mode_q    <= mode_d;
      cur_pos_q <= cur_pos_d;
      goal_q    <= goal_d;
      limit_q   <= limit_d;
      run_q     <= run_d;
      pulse_q   <= pulse_d;
    end
  end

  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.move_done |=> mode_q == MODE_STOPPED)
    else $error("motor still running after move_done");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(cur_pos_q) && $stable(mode_q) && $stable(run_q))
    else $error("tracker state changed without an item");

  a_stop_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && moving && item_i.operation == OP_STOP
    |=> cur_pos_q <= $past(cfg_i.max_position))
    else $error("stop estimate beyond full stroke");

endmodule

### rtl/tapt_round.sv
// rounds a position down to a multiple of one hundred
module tapt_round import tapt_pkg::*; (
  input  logic [PosW-1:0] pos_i,
  output logic [PosW-1:0] saved_o
);

  logic [PosW+17:0] prod;
  logic [9:0]       quot;

  assign prod    = {18'd0, pos_i} * {{PosW{1'b0}}, RecipHundred};
  assign quot    = prod[RecipShift +: 10];
  // quot * 100 as 64 + 32 + 4
  assign saved_o = {quot, 6'd0} + {1'b0, quot, 5'd0} + {4'd0, quot, 2'd0};

endmodule

### rtl/timed_actuator_position_tracker_top.sv
// top level of the timed actuator position tracker
// a result passes through the input register and then the result register before it is offered
// throughput: one item per cycle while the result is not stalled, set by the input and result registers
// a stalled result holds the result register; the input register takes one more item if it is empty, then stalls
// reset clears the valid flags and tracker state (stopped at position zero)
// reset loads the configuration registers with their default values
module timed_actuator_position_tracker_top import tapt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  tapt_in_if.sink          in_if,
  tapt_out_if.source       out_if,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t  cfg;
  item_t item_q;
  res_t  res, res_q;
  logic  in_valid_q, out_valid_q, adv;

  assign adv         = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_valid_q <= in_if.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      item_q.operation <= in_if.operation;
      item_q.target    <= in_if.target;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  tapt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tapt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  tapt_round u_round (
    .pos_i   (res_q.position),
    .saved_o (out_if.saved_position)
  );

  assign out_if.valid          = out_valid_q;
  assign out_if.drive_forward  = res_q.drive_forward;
  assign out_if.drive_backward = res_q.drive_backward;
  assign out_if.motion         = res_q.motion;
  assign out_if.position       = res_q.position;
  assign out_if.move_done      = res_q.move_done;

endmodule
